// ===== design/padded_integer_formatter_assert.svh =====
// Assertion macros used by the checker file of the padded integer formatter.
`ifndef PADDED_INTEGER_FORMATTER_ASSERT_SVH
`define PADDED_INTEGER_FORMATTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PIF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("padded integer formatter: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PIF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("padded integer formatter: assertion failed");

`endif

// ===== design/pif_pkg.sv =====
// Shared types, constants and a helper function of the padded integer formatter.
`default_nettype none

package pif_pkg;

  // Field widths of the input and result beats.
  localparam int VALUE_W  = 32;
  localparam int RADIX_W  = 5;
  localparam int FWIDTH_W = 6;
  localparam int FLAGS_W  = 5;
  localparam int CHAR_W   = 8;

  // Most characters one field may produce.
  localparam int OUT_LIMIT = 63;

  // Bit positions inside format_flags.
  localparam int FLAG_ZERO    = 0;
  localparam int FLAG_SIGNED  = 1;
  localparam int FLAG_PLUS    = 2;
  localparam int FLAG_LEFT    = 3;
  localparam int FLAG_CAPITAL = 4;

  // Sign character codes.
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;

  // Radix limits.
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    logic [RADIX_W-1:0]  radix;
    logic [FWIDTH_W-1:0] width;
    logic [1:0]          sign;
    logic                zero_pad;
    logic                left;
    logic                capital;
  } job_t;

  // ASCII character of one digit in the chosen letter case.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic capital);
    logic [CHAR_W-1:0] base;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      base = capital ? CH_UPPER_A : CH_LOWER_A;
      digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/pif_ifs.sv =====
// Valid/ready channel interfaces for the input values and the output characters.
`default_nettype none

interface pif_in_if;
  logic                            valid;
  logic                            ready;
  logic [pif_pkg::VALUE_W-1:0]     value;
  logic [pif_pkg::RADIX_W-1:0]     radix;
  logic [pif_pkg::FWIDTH_W-1:0]    field_width;
  logic [pif_pkg::FLAGS_W-1:0]     format_flags;

  modport source (output valid, value, radix, field_width, format_flags, input ready);
  modport sink (input valid, value, radix, field_width, format_flags, output ready);
endinterface

interface pif_out_if;
  logic                          valid;
  logic                          ready;
  logic [pif_pkg::CHAR_W-1:0]    out_char;
  logic                          last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink (input valid, out_char, last_char, output ready);
endinterface

`default_nettype wire

// ===== design/pif_front.sv =====
// Front end: accepts input beats, normalizes radix and width, resolves the sign.
`default_nettype none

module pif_front #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pif_in_if.sink                in_bus,
  output logic                  job_valid,
  input  logic                  job_ready,
  output pif_pkg::job_t         job,
  output logic [VALUE_BITS-1:0] job_mag
);

  logic                  vld_r;
  logic                  vld_nxt;
  pif_pkg::job_t         job_r;
  pif_pkg::job_t         job_nxt;
  logic [VALUE_BITS-1:0] mag_r;
  logic [VALUE_BITS-1:0] mag_nxt;
  logic [VALUE_BITS-1:0] val;
  logic                  neg;
  logic                  accept;

  assign in_bus.ready = !vld_r || job_ready;
  assign accept       = in_bus.valid && in_bus.ready;

  // Classify the incoming value: magnitude, sign, radix and width limits.
  always_comb begin
    val = VALUE_BITS'(in_bus.value);
    neg = in_bus.format_flags[pif_pkg::FLAG_SIGNED] && val[VALUE_BITS-1];
    mag_nxt = neg ? (~val + VALUE_BITS'(1)) : val;

    if (in_bus.radix < pif_pkg::RADIX_MIN) begin
      job_nxt.radix = pif_pkg::RADIX_DEFAULT;
    end else if (in_bus.radix > pif_pkg::RADIX_MAX) begin
      job_nxt.radix = pif_pkg::RADIX_MAX;
    end else begin
      job_nxt.radix = in_bus.radix;
    end

    if (in_bus.field_width > pif_pkg::FWIDTH_W'(MAX_WIDTH)) begin
      job_nxt.width = pif_pkg::FWIDTH_W'(MAX_WIDTH);
    end else begin
      job_nxt.width = in_bus.field_width;
    end

    if (neg) begin
      job_nxt.sign = pif_pkg::SIGN_MINUS;
    end else if (in_bus.format_flags[pif_pkg::FLAG_PLUS]) begin
      job_nxt.sign = pif_pkg::SIGN_PLUS;
    end else begin
      job_nxt.sign = pif_pkg::SIGN_NONE;
    end

    job_nxt.zero_pad = in_bus.format_flags[pif_pkg::FLAG_ZERO];
    job_nxt.left     = in_bus.format_flags[pif_pkg::FLAG_LEFT];
    job_nxt.capital  = in_bus.format_flags[pif_pkg::FLAG_CAPITAL];
  end

  // Output stage valid flag.
  always_comb begin
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (job_ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload is captured on every accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign job_valid = vld_r;
  assign job       = job_r;
  assign job_mag   = mag_r;

endmodule

`default_nettype wire

// ===== design/pif_queue.sv =====
// Short job queue between the front end and the back end.
`default_nettype none

module pif_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/pif_back.sv =====
// Back end: digit extraction by repeated division, field sizing and character output.
`default_nettype none

module pif_back #(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_SLOTS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  pif_pkg::job_t         job,
  input  logic [VALUE_BITS-1:0] job_mag,
  pif_out_if.source             out_bus
);

  localparam int STEPS  = (VALUE_BITS + 7) / 8;
  localparam int DW     = STEPS * 8;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CNT_W  = $clog2(DIGIT_SLOTS + 1);
  localparam int POS_W  = $clog2(DIGIT_SLOTS + pif_pkg::OUT_LIMIT + 2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SIZE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                  state_r;
  logic [1:0]                  state_nxt;
  pif_pkg::job_t               job_r;
  logic [DW-1:0]               q_r;
  logic [3:0]                  rem_r;
  logic [STEP_W-1:0]           step_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [3:0]                  dig_r [DIGIT_SLOTS];
  logic [POS_W-1:0]            lead_r;
  logic [POS_W-1:0]            sign_end_r;
  logic [POS_W-1:0]            d0_r;
  logic [POS_W-1:0]            d1_r;
  logic [POS_W-1:0]            last_pos_r;
  logic [POS_W-1:0]            pos_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [pif_pkg::CHAR_W-1:0]  out_char_r;
  logic                        out_last_r;

  logic [DW-1:0]               q_t;
  logic [3:0]                  rem_t;
  logic [4:0]                  acc;
  logic                        last_step;
  logic                        div_done;
  logic                        push;
  logic                        has_sign;
  logic [POS_W-1:0]            used;
  logic [POS_W-1:0]            wid;
  logic [POS_W-1:0]            pad;
  logic [POS_W-1:0]            lead;
  logic [POS_W-1:0]            zpad;
  logic [POS_W-1:0]            sign_end;
  logic [POS_W-1:0]            d0;
  logic [POS_W-1:0]            total;
  logic                        emit_go;
  logic                        pop;
  logic [pif_pkg::CHAR_W-1:0]  char_nxt;
  logic                        is_last;

  assign job_ready = state_r == ST_IDLE;

  // Eight bits of restoring division by the radix per cycle.
  always_comb begin
    q_t   = q_r;
    rem_t = rem_r;
    acc   = '0;
    for (int b = 0; b < 8; b++) begin
      acc = {rem_t, q_t[DW-1]};
      q_t = {q_t[DW-2:0], 1'b0};
      if (acc >= job_r.radix) begin
        acc    = acc - job_r.radix;
        q_t[0] = 1'b1;
      end
      rem_t = acc[3:0];
    end
  end

  assign last_step = step_r == STEP_W'(STEPS - 1);
  assign push      = (state_r == ST_DIV) && last_step;
  assign div_done  = push && ((q_t == '0) || (cnt_r == CNT_W'(DIGIT_SLOTS - 1)));

  // Field layout: leading spaces, sign, zeros, digits, trailing spaces.
  always_comb begin
    has_sign = job_r.sign != pif_pkg::SIGN_NONE;
    used     = POS_W'(cnt_r) + POS_W'(has_sign);
    wid      = POS_W'(job_r.width);
    pad      = (wid > used) ? wid - used : '0;
    lead     = (!job_r.zero_pad && !job_r.left) ? pad : '0;
    zpad     = (job_r.zero_pad && !job_r.left) ? pad : '0;
    sign_end = lead + POS_W'(has_sign);
    d0       = sign_end + zpad;
    total    = used + pad;
    if (total > POS_W'(pif_pkg::OUT_LIMIT)) begin
      total = POS_W'(pif_pkg::OUT_LIMIT);
    end
  end

  // Character at the current field position.
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_bus.ready);
  assign is_last = pos_r == last_pos_r;

  always_comb begin
    pop = 1'b0;
    if (pos_r < lead_r) begin
      char_nxt = pif_pkg::CH_SPACE;
    end else if (pos_r < sign_end_r) begin
      char_nxt = (job_r.sign == pif_pkg::SIGN_MINUS) ? pif_pkg::CH_MINUS : pif_pkg::CH_PLUS;
    end else if (pos_r < d0_r) begin
      char_nxt = pif_pkg::CH_ZERO;
    end else if (pos_r < d1_r) begin
      char_nxt = pif_pkg::digit_char(dig_r[0], job_r.capital);
      pop      = emit_go;
    end else begin
      char_nxt = pif_pkg::CH_SPACE;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go && is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Division datapath and digit count.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && job_valid) begin
      job_r  <= job;
      q_r    <= DW'(job_mag);
      rem_r  <= '0;
      step_r <= '0;
      cnt_r  <= '0;
    end else if (state_r == ST_DIV) begin
      q_r <= q_t;
      if (last_step) begin
        rem_r  <= '0;
        step_r <= '0;
        cnt_r  <= cnt_r + CNT_W'(1);
      end else begin
        rem_r  <= rem_t;
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  // Digit stack: least significant digit pushed first, most significant popped first.
  always_ff @(posedge clk) begin
    if (push) begin
      dig_r[0] <= rem_t;
      for (int i = 1; i < DIGIT_SLOTS; i++) begin
        dig_r[i] <= dig_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < DIGIT_SLOTS - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
    end
  end

  // Layout boundaries and position counter.
  always_ff @(posedge clk) begin
    if (state_r == ST_SIZE) begin
      lead_r     <= lead;
      sign_end_r <= sign_end;
      d0_r       <= d0;
      d1_r       <= d0 + POS_W'(cnt_r);
      last_pos_r <= total - POS_W'(1);
      pos_r      <= '0;
    end else if (emit_go) begin
      pos_r <= pos_r + POS_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_char_r <= char_nxt;
      out_last_r <= is_last;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_char  = out_char_r;
  assign out_bus.last_char = out_last_r;

endmodule

`default_nettype wire

// ===== design/padded_integer_formatter.sv =====
// Path: a value beat is registered in the front end, held in the queue and taken by an idle
// back end, which extracts the digits with a byte-per-cycle divider, sizes the field in ST_SIZE
// and emits it through the single character output register. The back end takes no new value
// until the last character of its field has been emitted.
// The front end and a two-entry queue take further values while the back end works.
// Reset: rst_n is synchronous, active low, and clears all handshake and sequencer state.
`default_nettype none

module padded_integer_formatter #(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_SLOTS = 32,
  parameter int MAX_WIDTH   = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  pif_in_if.sink     in_bus,
  pif_out_if.source  out_bus
);

  localparam int JOB_W = $bits(pif_pkg::job_t);
  localparam int Q_W   = VALUE_BITS + JOB_W;

  logic                  f_valid;
  logic                  f_ready;
  pif_pkg::job_t         f_job;
  logic [VALUE_BITS-1:0] f_mag;
  logic                  b_valid;
  logic                  b_ready;
  logic [Q_W-1:0]        b_data;
  pif_pkg::job_t         b_job;
  logic [VALUE_BITS-1:0] b_mag;

  // Accept and classify.
  pif_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job),
    .job_mag   (f_mag)
  );

  // Decouple the two halves.
  pif_queue #(
    .DATA_W (Q_W),
    .DEPTH  (2)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_mag, f_job}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  assign b_job = b_data[JOB_W-1:0];
  assign b_mag = b_data[Q_W-1:JOB_W];

  // Digits and characters.
  pif_back #(
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .job_mag   (b_mag),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire

// ===== design/pif_checker.sv =====
// Port-level checker of the padded integer formatter and its bind.
`default_nettype none
`include "padded_integer_formatter_assert.svh"

module pif_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pif_pkg::CHAR_W-1:0] out_char,
  input logic                       out_last
);

  logic [7:0] pend_r;
  logic [6:0] chars_r;
  logic       in_fire;
  logic       out_fire;
  logic       field_end;
  logic       char_ok;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign field_end = out_fire && out_last;

  assign char_ok = (out_char == pif_pkg::CH_SPACE) || (out_char == pif_pkg::CH_PLUS) ||
                   (out_char == pif_pkg::CH_MINUS) ||
                   ((out_char >= pif_pkg::CH_ZERO) && (out_char <= pif_pkg::CH_NINE)) ||
                   ((out_char >= pif_pkg::CH_UPPER_A) && (out_char <= pif_pkg::CH_UPPER_F)) ||
                   ((out_char >= pif_pkg::CH_LOWER_A) && (out_char <= pif_pkg::CH_LOWER_F));

  // Values accepted whose field has not been closed yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_fire && !field_end) begin
      pend_r <= pend_r + 8'd1;
    end else if (field_end && !in_fire) begin
      pend_r <= pend_r - 8'd1;
    end
  end

  // Characters already delivered in the open field.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r <= '0;
    end else if (field_end) begin
      chars_r <= '0;
    end else if (out_fire) begin
      chars_r <= chars_r + 7'd1;
    end
  end

  `PIF_ASSERT_IMP(a_out_has_value, out_valid, pend_r != 8'd0)
  `PIF_ASSERT_IMP(a_char_legal, out_valid, char_ok)
  `PIF_ASSERT_IMP(a_field_limit, out_valid && !out_last, chars_r < 7'(pif_pkg::OUT_LIMIT - 1))
  `PIF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last))

endmodule

bind padded_integer_formatter pif_checker u_pif_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_char  (out_bus.out_char),
  .out_last  (out_bus.last_char)
);

`default_nettype wire

// ===== tb/field_char_checker.sv =====
// Watches the value and character channels, predicts every field and compares each character.
`timescale 1ns / 100ps

module field_char_checker (
  input  logic      clk,
  input  logic      rst_n,
  pif_in_if         in_mon,
  pif_out_if        out_mon,
  output int        fail_count,
  output int        expected_left
);

  // Digit glyphs, first character in the top byte.
  localparam logic [127:0] UPPER_GLYPHS = "0123456789ABCDEF";
  localparam logic [127:0] LOWER_GLYPHS = "0123456789abcdef";

  typedef struct packed {
    logic [pif_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } glyph_t;

  glyph_t pending_chars[$];
  int     mismatches = 0;

  // Builds the whole padded field for one value beat and queues its characters.
  function automatic void predict_field(input logic [pif_pkg::VALUE_W-1:0] value,
                                        input logic [pif_pkg::RADIX_W-1:0] radix_in,
                                        input logic [pif_pkg::FWIDTH_W-1:0] width_in,
                                        input logic [pif_pkg::FLAGS_W-1:0] flags);
    logic [pif_pkg::VALUE_W-1:0] mag;
    logic [pif_pkg::RADIX_W-1:0] base;
    logic [1:0]                  sign_kind;
    logic [pif_pkg::CHAR_W-1:0]  digit_chars[$];
    logic [pif_pkg::CHAR_W-1:0]  line_chars[$];
    glyph_t                      g;
    int                          rem;
    int                          used;
    int                          pad;
    int                          count;
    mag = value;
    if (radix_in < pif_pkg::RADIX_MIN) begin
      base = pif_pkg::RADIX_DEFAULT;
    end else if (radix_in > pif_pkg::RADIX_MAX) begin
      base = pif_pkg::RADIX_MAX;
    end else begin
      base = radix_in;
    end

    // A negative signed value overrides the plus flag and is shown as its magnitude.
    sign_kind = flags[pif_pkg::FLAG_PLUS] ? pif_pkg::SIGN_PLUS : pif_pkg::SIGN_NONE;
    if (flags[pif_pkg::FLAG_SIGNED] && value[pif_pkg::VALUE_W-1]) begin
      sign_kind = pif_pkg::SIGN_MINUS;
      mag = -value;
    end

    // Digits come out least significant first, so build the string from the front.
    do begin
      rem = int'(mag % base);
      mag = mag / base;
      if (flags[pif_pkg::FLAG_CAPITAL]) begin
        digit_chars.push_front(UPPER_GLYPHS[(15 - rem) * 8 +: 8]);
      end else begin
        digit_chars.push_front(LOWER_GLYPHS[(15 - rem) * 8 +: 8]);
      end
    end while (mag != 0);

    used = digit_chars.size() + ((sign_kind != pif_pkg::SIGN_NONE) ? 1 : 0);
    pad = (int'(width_in) > used) ? int'(width_in) - used : 0;

    // Right justified with spaces, zero filled after the sign, or left justified.
    if (!flags[pif_pkg::FLAG_ZERO] && !flags[pif_pkg::FLAG_LEFT]) begin
      repeat (pad) line_chars.push_back(pif_pkg::CH_SPACE);
    end
    if (sign_kind == pif_pkg::SIGN_MINUS) begin
      line_chars.push_back(pif_pkg::CH_MINUS);
    end else if (sign_kind == pif_pkg::SIGN_PLUS) begin
      line_chars.push_back(pif_pkg::CH_PLUS);
    end
    if (flags[pif_pkg::FLAG_ZERO] && !flags[pif_pkg::FLAG_LEFT]) begin
      repeat (pad) line_chars.push_back(pif_pkg::CH_ZERO);
    end
    foreach (digit_chars[i]) line_chars.push_back(digit_chars[i]);
    if (flags[pif_pkg::FLAG_LEFT]) begin
      repeat (pad) line_chars.push_back(pif_pkg::CH_SPACE);
    end

    count = (line_chars.size() > pif_pkg::OUT_LIMIT) ? pif_pkg::OUT_LIMIT : line_chars.size();
    for (int i = 0; i < count; i++) begin
      g.ch = line_chars[i];
      g.last = (i == count - 1);
      pending_chars.push_back(g);
    end
  endfunction

  function automatic void note_mismatch(input string what, input glyph_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t: %s: expected char %h last %b, got char %h last %b", $time, what,
               want.ch, want.last, out_mon.out_char, out_mon.last_char);
    end
  endfunction

  // Predictions are queued before the character beat of the same edge is checked.
  always @(posedge clk) begin
    glyph_t want;
    if (!rst_n) begin
      pending_chars.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_field(in_mon.value, in_mon.radix, in_mon.field_width, in_mon.format_flags);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_chars.size() == 0) begin
          note_mismatch("character with none expected", '0);
        end else begin
          want = pending_chars.pop_front();
          if (out_mon.out_char !== want.ch || out_mon.last_char !== want.last) begin
            note_mismatch("character mismatch", want);
          end
        end
      end
    end
    expected_left <= pending_chars.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the formatter testbench: clock, reset, value stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS = 430;
  // Longest legal quiet stretch is a radix 2 division plus a long stall and a long gap.
  localparam int IDLE_LIMIT   = 4000;

  localparam int VW = pif_pkg::VALUE_W;
  localparam int RW = pif_pkg::RADIX_W;
  localparam int WW = pif_pkg::FWIDTH_W;
  localparam int FW = pif_pkg::FLAGS_W;

  localparam logic [FW-1:0] F_ZERO    = FW'(1 << pif_pkg::FLAG_ZERO);
  localparam logic [FW-1:0] F_SIGNED  = FW'(1 << pif_pkg::FLAG_SIGNED);
  localparam logic [FW-1:0] F_PLUS    = FW'(1 << pif_pkg::FLAG_PLUS);
  localparam logic [FW-1:0] F_LEFT    = FW'(1 << pif_pkg::FLAG_LEFT);
  localparam logic [FW-1:0] F_CAPITAL = FW'(1 << pif_pkg::FLAG_CAPITAL);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   expected_left;
  int   burst_left;
  int   idle_cycles = 0;

  pif_in_if  in_bus ();
  pif_out_if out_bus ();

  padded_integer_formatter uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  field_char_checker chars_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sends one value beat, then ends the burst with a gap when its length runs out.
  task automatic send_value(input logic [VW-1:0] v, input logic [RW-1:0] base,
                            input logic [WW-1:0] fw, input logic [FW-1:0] flags);
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    in_bus.radix <= base;
    in_bus.field_width <= fw;
    in_bus.format_flags <= flags;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_bus.valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
  endtask

  // Holds the sender off until every queued character has been taken.
  task automatic wait_fields_done();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  // Receiver: ready runs of random length broken by stalls, now and then a long clear run.
  initial begin
    int run_len;
    int stall_len;
    out_bus.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      stall_len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      out_bus.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (stall_len > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [VW-1:0] v;
    logic [RW-1:0] base;
    logic [WW-1:0] fw;
    in_bus.valid = 1'b0;
    in_bus.value = '0;
    in_bus.radix = '0;
    in_bus.field_width = '0;
    in_bus.format_flags = '0;
    burst_left = 4;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, sign handling, every padding mode and the radix corner cases.
    send_value(32'd0, 5'd10, 6'd0, 5'd0);
    send_value(32'hFFFF_FFFF, 5'd10, 6'd0, 5'd0);
    send_value(32'hFFFF_FFFF, 5'd10, 6'd0, F_SIGNED);
    send_value(32'h8000_0000, 5'd10, 6'd0, F_SIGNED);
    send_value(32'h7FFF_FFFF, 5'd10, 6'd0, F_SIGNED | F_PLUS);
    send_value(32'hFFFF_FFFF, 5'd2, 6'd63, F_LEFT);
    send_value(32'd0, 5'd2, 6'd63, 5'd0);
    send_value(32'hDEAD_BEEF, 5'd16, 6'd12, F_ZERO | F_CAPITAL);
    send_value(32'hABCD_EF01, 5'd16, 6'd9, 5'd0);
    send_value(32'd12345, 5'd0, 6'd8, F_PLUS);
    send_value(32'd12345, 5'd1, 6'd8, F_ZERO);
    send_value(32'h0BAD_CAFE, 5'd17, 6'd0, F_CAPITAL);
    send_value(32'h0BAD_CAFE, 5'd31, 6'd3, 5'd0);
    send_value(32'hFFFF_FF85, 5'd10, 6'd63, F_ZERO | F_SIGNED);
    send_value(32'd42, 5'd10, 6'd10, F_ZERO | F_LEFT | F_PLUS);
    send_value(32'd42, 5'd10, 6'd10, F_ZERO | F_PLUS);
    send_value(32'hFFFF_FFFF, 5'd8, 6'd2, 5'd0);
    send_value(32'd177, 5'd3, 6'd6, F_LEFT);
    send_value(32'd99, 5'd7, 6'd1, F_PLUS | F_LEFT);
    send_value(32'hF000_0001, 5'd16, 6'd63, 5'h1F);
    send_value(32'h8000_0000, 5'd2, 6'd40, F_SIGNED | F_ZERO);
    send_value(32'd0, 5'd16, 6'd5, F_SIGNED | F_PLUS | F_ZERO);
    wait_fields_done();

    // Random values with a bias toward small numbers, negatives and extremes.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      case ($urandom_range(0, 7))
        0: v = VW'($urandom_range(0, 15));
        1: v = VW'(-$urandom_range(1, 1000));
        2: begin
          case ($urandom_range(0, 3))
            0: v = 32'd0;
            1: v = 32'hFFFF_FFFF;
            2: v = 32'h8000_0000;
            default: v = 32'h7FFF_FFFF;
          endcase
        end
        3: v = 32'd1 << $urandom_range(0, 31);
        default: v = VW'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1: base = 5'd10;
        2: base = 5'd16;
        3: base = 5'd2;
        4: base = 5'd8;
        5, 6: base = RW'($urandom_range(2, 16));
        7: base = RW'($urandom_range(0, 1));
        8: base = RW'($urandom_range(17, 31));
        default: base = RW'($urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2, 3, 4: fw = WW'($urandom_range(0, 12));
        5, 6: fw = WW'($urandom_range(13, 40));
        default: fw = WW'($urandom_range(41, 63));
      endcase
      send_value(v, base, fw, FW'($urandom_range(0, 31)));
      if (k == 150 || k == 300) begin
        wait_fields_done();
      end
    end

    // Drain, then leave room for any stray character before the verdict.
    wait_fields_done();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/pif_pkg.sv
design/pif_ifs.sv
design/pif_front.sv
design/pif_queue.sv
design/pif_back.sv
design/padded_integer_formatter.sv
design/pif_checker.sv
tb/field_char_checker.sv
tb/testbench.sv
